### src/dds_frequency_sweep_word_generator_macros.svh
// ----------------------------------------------------------------------------
// dds frequency sweep word generator assertion macros
// shared property wrappers clocked on aclk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef DDS_FREQUENCY_SWEEP_WORD_GENERATOR_MACROS_SVH
`define DDS_FREQUENCY_SWEEP_WORD_GENERATOR_MACROS_SVH

// same-cycle implication
`define DFSW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dfsw assertion failed");

// next-cycle implication
`define DFSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dfsw assertion failed");

`endif

### src/dfsw_pkg.sv
// ----------------------------------------------------------------------------
// dfsw_pkg
// types, codes and constants of the dds frequency sweep word generator
// ----------------------------------------------------------------------------
`default_nettype none

package dfsw_pkg;

    localparam int FREQ_BITS_DEF = 24;
    localparam int CFG_W         = 24;
    localparam int IDX_W         = 3;
    localparam int TW_W          = 28;
    localparam int TW_SHIFT      = 24;
    localparam int WORD_W        = 16;

    localparam logic [TW_W-1:0]   TW_MULT     = 28'd180143985;
    localparam logic [TW_W-1:0]   TW_HALF     = 28'h0800000;
    localparam logic [TW_W-1:0]   TW_MAX      = 28'hFFFFFFF;
    localparam logic [1:0]        REG_SEL     = 2'b01;
    localparam logic [WORD_W-1:0] PHASE_WORD  = 16'hC000;
    localparam logic [WORD_W-1:0] CTRL_D28    = 16'h2000;
    localparam logic [WORD_W-1:0] CTRL_RESET  = 16'h0100;
    localparam logic [WORD_W-1:0] CTRL_SQUARE = 16'h0028;
    localparam logic [WORD_W-1:0] CTRL_TRI    = 16'h0002;
    localparam int                RESET_FREQ  = 1000;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2
    } waveform_t;

    typedef enum logic [1:0] {
        SWEEP_BOUNCE = 2'd0,
        SWEEP_RISE   = 2'd1,
        SWEEP_FALL   = 2'd2
    } sweep_mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_WAVEFORM     = 3'd0,
        REG_SWEEP_ENABLE = 3'd1,
        REG_SWEEP_MODE   = 3'd2,
        REG_LOWER_FREQ   = 3'd3,
        REG_UPPER_FREQ   = 3'd4,
        REG_FREQ_STEP    = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        WORD_CTRL_RST = 3'd0,
        WORD_TW_LSB   = 3'd1,
        WORD_TW_MSB   = 3'd2,
        WORD_PHASE    = 3'd3,
        WORD_CTRL     = 3'd4
    } word_sel_t;

    localparam logic [0:0] ITEM_TICK = 1'b0;
    localparam logic [0:0] ITEM_LOAD = 1'b1;

    typedef struct packed {
        waveform_t        waveform;
        logic             sweep_enable;
        sweep_mode_t      sweep_mode;
        logic [CFG_W-1:0] lower_freq;
        logic [CFG_W-1:0] upper_freq;
        logic [CFG_W-1:0] freq_step;
    } cfg_t;

endpackage

`default_nettype wire

### src/dfsw_sweep.sv
// ----------------------------------------------------------------------------
// dfsw_sweep
// frequency and direction state, applies a load or a sweep tick per request
// ----------------------------------------------------------------------------
`default_nettype none

module dfsw_sweep #(
    parameter int FREQ_BITS = dfsw_pkg::FREQ_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dfsw_pkg::cfg_t              cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_mode,
    input  wire logic [dfsw_pkg::CFG_W-1:0]  in_new_freq,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [FREQ_BITS-1:0]             out_freq
);

    localparam int SUM_W = ((FREQ_BITS > dfsw_pkg::CFG_W) ? FREQ_BITS : dfsw_pkg::CFG_W) + 1;
    localparam logic [SUM_W-1:0] FMAX = {{(SUM_W-FREQ_BITS){1'b0}}, {FREQ_BITS{1'b1}}};

    logic [FREQ_BITS-1:0] freq_reg, freq_next;
    logic                 up_reg, up_next;
    logic                 valid_reg, valid_next;
    logic [FREQ_BITS-1:0] out_freq_reg, out_freq_next;

    logic [FREQ_BITS-1:0] lo, hi, cur, step_freq;
    logic [SUM_W-1:0]     cur_ext, st_ext;
    logic                 up;
    logic                 accept;

    function automatic logic [FREQ_BITS-1:0] sat_f(input logic [SUM_W-1:0] v);
        return (v > FMAX) ? FMAX[FREQ_BITS-1:0] : v[FREQ_BITS-1:0];
    endfunction

    always_comb begin
        lo     = sat_f(SUM_W'(cfg.lower_freq));
        hi     = sat_f(SUM_W'(cfg.upper_freq));
        st_ext = SUM_W'(cfg.freq_step);
        cur    = freq_reg;
        up     = up_reg;
        case (cfg.sweep_mode)
            dfsw_pkg::SWEEP_BOUNCE: begin
                if (cur >= hi) begin
                    up = 1'b0;
                end else if (cur <= lo) begin
                    up = 1'b1;
                end
            end
            dfsw_pkg::SWEEP_RISE: begin
                up = 1'b1;
                if (cur >= hi) begin
                    cur = lo;
                end
            end
            dfsw_pkg::SWEEP_FALL: begin
                up = 1'b0;
                if (cur <= lo) begin
                    cur = hi;
                end
            end
            default: begin
            end
        endcase
        cur_ext = SUM_W'(cur);
        if (up) begin
            step_freq = sat_f(cur_ext + st_ext);
        end else if (cur_ext >= st_ext) begin
            step_freq = FREQ_BITS'(cur_ext - st_ext);
        end else begin
            step_freq = '0;
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        freq_next     = freq_reg;
        up_next       = up_reg;
        valid_next    = valid_reg && !out_ready;
        out_freq_next = out_freq_reg;
        if (accept) begin
            if (in_mode == dfsw_pkg::ITEM_LOAD) begin
                freq_next     = sat_f(SUM_W'(in_new_freq));
                valid_next    = 1'b1;
                out_freq_next = sat_f(SUM_W'(in_new_freq));
            end else if (cfg.sweep_enable) begin
                freq_next     = step_freq;
                up_next       = up;
                valid_next    = 1'b1;
                out_freq_next = step_freq;
            end else begin
                valid_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg  <= FREQ_BITS'(dfsw_pkg::RESET_FREQ);
            up_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            freq_reg  <= freq_next;
            up_reg    <= up_next;
            valid_reg <= valid_next;
        end
        out_freq_reg <= out_freq_next;
    end

    assign out_valid = valid_reg;
    assign out_freq  = out_freq_reg;

endmodule

`default_nettype wire

### src/dfsw_tuning.sv
// ----------------------------------------------------------------------------
// dfsw_tuning
// registered product of the frequency and the tuning word scale factor
// ----------------------------------------------------------------------------
`default_nettype none

module dfsw_tuning #(
    parameter int FREQ_BITS = dfsw_pkg::FREQ_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [FREQ_BITS-1:0]                  in_freq,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [FREQ_BITS+dfsw_pkg::TW_W-1:0]        out_prod
);

    localparam int PROD_W = FREQ_BITS + dfsw_pkg::TW_W;

    logic              valid_reg, valid_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg && !out_ready;
        prod_next  = prod_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            prod_next  = PROD_W'(in_freq) * PROD_W'(dfsw_pkg::TW_MULT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        prod_reg <= prod_next;
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;

endmodule

`default_nettype wire

### src/dfsw_serializer.sv
// ----------------------------------------------------------------------------
// dfsw_serializer
// rounds the tuning word and sends the five dds words of one update in order
// ----------------------------------------------------------------------------
`default_nettype none

module dfsw_serializer #(
    parameter int FREQ_BITS = dfsw_pkg::FREQ_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire dfsw_pkg::waveform_t                 waveform,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [FREQ_BITS+dfsw_pkg::TW_W-1:0] in_prod,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [dfsw_pkg::WORD_W-1:0]              m_spi_word,
    output logic                                     m_last_word
);

    localparam int PROD_W = FREQ_BITS + dfsw_pkg::TW_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int TWF_W  = ((SUM_W - dfsw_pkg::TW_SHIFT) > dfsw_pkg::TW_W) ?
                            (SUM_W - dfsw_pkg::TW_SHIFT) : dfsw_pkg::TW_W;

    logic                          valid_reg, valid_next;
    dfsw_pkg::word_sel_t           sel_reg, sel_next;
    logic [dfsw_pkg::TW_W-1:0]     tw_reg, tw_next;

    logic [SUM_W-1:0]              rounded;
    logic [TWF_W-1:0]              tw_full;
    logic [dfsw_pkg::TW_W-1:0]     tw_sat;
    logic [dfsw_pkg::WORD_W-1:0]   ctrl;
    logic                          last;

    always_comb begin
        rounded = SUM_W'(in_prod) + SUM_W'(dfsw_pkg::TW_HALF);
        tw_full = TWF_W'(rounded >> dfsw_pkg::TW_SHIFT);
        tw_sat  = (tw_full > TWF_W'(dfsw_pkg::TW_MAX)) ? dfsw_pkg::TW_MAX
                                                        : tw_full[dfsw_pkg::TW_W-1:0];
    end

    assign last     = (sel_reg == dfsw_pkg::WORD_CTRL);
    assign in_ready = !valid_reg || (m_ready && last);

    always_comb begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        tw_next    = tw_reg;
        if (valid_reg && m_ready) begin
            if (last) begin
                valid_next = 1'b0;
            end else begin
                sel_next = dfsw_pkg::word_sel_t'(sel_reg + 3'd1);
            end
        end
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            sel_next   = dfsw_pkg::WORD_CTRL_RST;
            tw_next    = tw_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= dfsw_pkg::WORD_CTRL_RST;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
        tw_reg <= tw_next;
    end

    always_comb begin
        case (waveform)
            dfsw_pkg::WAVE_SQUARE:   ctrl = dfsw_pkg::CTRL_D28 | dfsw_pkg::CTRL_SQUARE;
            dfsw_pkg::WAVE_TRIANGLE: ctrl = dfsw_pkg::CTRL_D28 | dfsw_pkg::CTRL_TRI;
            default:                 ctrl = dfsw_pkg::CTRL_D28;
        endcase
        case (sel_reg)
            dfsw_pkg::WORD_CTRL_RST: m_spi_word = ctrl | dfsw_pkg::CTRL_RESET;
            dfsw_pkg::WORD_TW_LSB:   m_spi_word = {dfsw_pkg::REG_SEL, tw_reg[13:0]};
            dfsw_pkg::WORD_TW_MSB:   m_spi_word = {dfsw_pkg::REG_SEL, tw_reg[27:14]};
            dfsw_pkg::WORD_PHASE:    m_spi_word = dfsw_pkg::PHASE_WORD;
            dfsw_pkg::WORD_CTRL:     m_spi_word = ctrl;
            default:                 m_spi_word = ctrl;
        endcase
    end

    assign m_valid     = valid_reg;
    assign m_last_word = last;

endmodule

`default_nettype wire

### src/dds_frequency_sweep_word_generator.sv
// ----------------------------------------------------------------------------
// dds_frequency_sweep_word_generator
// Each accepted request either loads a new frequency or, with sweeping on,
// steps the current frequency by the configured step (bounce, rise-wrap or
// fall-wrap between the limits), then emits five 16-bit dds words: control
// with reset, tuning word lsb, tuning word msb, phase, control. The first
// word is valid after the sweep, tuning and serializer registers; the
// serializer sends one word per cycle while m_ready is high and takes a
// new update only as the last word of the one before is taken. A tick
// with sweeping off is taken and produces no words. Up to three requests are
// in flight across the sweep, multiply and serializer stages. Configuration
// writes are taken every cycle and must only come while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dds_frequency_sweep_word_generator_macros.svh"

module dds_frequency_sweep_word_generator #(
    parameter int FREQ_BITS = dfsw_pkg::FREQ_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dfsw_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [dfsw_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_mode,
    input  wire logic [dfsw_pkg::CFG_W-1:0]  s_new_freq,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [dfsw_pkg::WORD_W-1:0]      m_spi_word,
    output logic                             m_last_word
);

    localparam int PROD_W = FREQ_BITS + dfsw_pkg::TW_W;

    dfsw_pkg::cfg_t       cfg_reg, cfg_next;

    logic                 sw_valid, sw_ready;
    logic [FREQ_BITS-1:0] sw_freq;
    logic                 tn_valid, tn_ready;
    logic [PROD_W-1:0]    tn_prod;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (dfsw_pkg::reg_index_t'(cfg_index))
                dfsw_pkg::REG_WAVEFORM:
                    cfg_next.waveform = dfsw_pkg::waveform_t'(cfg_data[1:0]);
                dfsw_pkg::REG_SWEEP_ENABLE:
                    cfg_next.sweep_enable = cfg_data[0];
                dfsw_pkg::REG_SWEEP_MODE:
                    cfg_next.sweep_mode = dfsw_pkg::sweep_mode_t'(cfg_data[1:0]);
                dfsw_pkg::REG_LOWER_FREQ: cfg_next.lower_freq = cfg_data;
                dfsw_pkg::REG_UPPER_FREQ: cfg_next.upper_freq = cfg_data;
                dfsw_pkg::REG_FREQ_STEP:  cfg_next.freq_step  = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dfsw_sweep #(
        .FREQ_BITS (FREQ_BITS)
    ) u_sweep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_mode     (s_mode),
        .in_new_freq (s_new_freq),
        .out_valid   (sw_valid),
        .out_ready   (sw_ready),
        .out_freq    (sw_freq)
    );

    dfsw_tuning #(
        .FREQ_BITS (FREQ_BITS)
    ) u_tuning (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sw_valid),
        .in_ready  (sw_ready),
        .in_freq   (sw_freq),
        .out_valid (tn_valid),
        .out_ready (tn_ready),
        .out_prod  (tn_prod)
    );

    dfsw_serializer #(
        .FREQ_BITS (FREQ_BITS)
    ) u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .waveform    (cfg_reg.waveform),
        .in_valid    (tn_valid),
        .in_ready    (tn_ready),
        .in_prod     (tn_prod),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_spi_word  (m_spi_word),
        .m_last_word (m_last_word)
    );

    // a load always reaches the sweep stage output
    `DFSW_ASSERT_NEXT(a_load_emits, s_valid && s_ready && s_mode, sw_valid)

    // a tick with sweeping off leaves no update behind
    `DFSW_ASSERT_NEXT(a_idle_tick_silent,
        s_valid && s_ready && !s_mode && !cfg_reg.sweep_enable, !sw_valid)

    // output goes quiet after the last word when nothing is queued
    `DFSW_ASSERT_NEXT(a_last_word_drains,
        m_valid && m_ready && m_last_word && !tn_valid, !m_valid)

    // the reset control word never closes a sequence
    `DFSW_ASSERT_SAME(a_last_no_reset_bit, m_valid && m_last_word, !m_spi_word[8])

endmodule

`default_nettype wire

### test/dds_frequency_sweep_word_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dds_frequency_sweep_word_generator_test
// Self-checking bench for the dds sweep word generator. Requests go in over
// a valid/ready channel in random bursts. Configuration is rewritten between
// phases while the block is idle. A built-in sweep and tuning-word
// calculation predicts the five dds words of each update. Every word from
// the output channel is compared with the oldest predicted word while the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------

module dds_frequency_sweep_word_generator_test;

    localparam int          CLK_PERIOD    = 20;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          TARGET_ITEMS  = 130;
    localparam logic [63:0] TUNE_MULT     = 64'd180143985;
    localparam logic [63:0] TUNE_ROUND    = 64'h0080_0000;
    localparam int          TUNE_SHIFT    = 24;
    localparam logic [63:0] TUNE_MAX      = 64'h0FFF_FFFF;
    localparam int          CFG_W         = dfsw_pkg::CFG_W;
    localparam int          WORD_W        = dfsw_pkg::WORD_W;
    localparam int          TW_W          = dfsw_pkg::TW_W;
    localparam logic [CFG_W-1:0] FREQ_TOP = {CFG_W{1'b1}};

    typedef struct packed {
        logic [WORD_W-1:0] spi_word;
        logic              last_word;
    } dds_word_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [dfsw_pkg::IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_mode = dfsw_pkg::ITEM_TICK;
    logic [CFG_W-1:0]           s_new_freq = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [WORD_W-1:0]          m_spi_word;
    logic                       m_last_word;

    // predicted device state and settings
    logic [CFG_W-1:0]   freq_hz = CFG_W'(dfsw_pkg::RESET_FREQ);
    logic               going_up = 1'b0;
    logic [1:0]         set_wave = '0;
    logic               set_enable = 1'b0;
    logic [1:0]         set_mode = '0;
    logic [CFG_W-1:0]   set_lower = '0;
    logic [CFG_W-1:0]   set_upper = '0;
    logic [CFG_W-1:0]   set_step = '0;

    dds_word_t          dds_words_q[$];

    int                 fail_count = 0;
    int                 words_checked = 0;
    int                 loads_sent = 0;
    int                 ticks_sent = 0;
    int                 burst_left = 0;
    logic               gaps_on = 1'b1;
    int                 stall_style = 0;
    int                 stall_cycles = 0;

    dds_frequency_sweep_word_generator uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_new_freq  (s_new_freq),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_spi_word  (m_spi_word),
        .m_last_word (m_last_word)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(2_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic void queue_dds_words();
        logic [63:0]       scaled;
        logic [TW_W-1:0]   tune;
        logic [WORD_W-1:0] ctrl;
        scaled = (64'(freq_hz) * TUNE_MULT + TUNE_ROUND) >> TUNE_SHIFT;
        tune = (scaled > TUNE_MAX) ? TUNE_MAX[TW_W-1:0] : scaled[TW_W-1:0];
        ctrl = dfsw_pkg::CTRL_D28;
        if (set_wave == dfsw_pkg::WAVE_SQUARE) begin
            ctrl = ctrl | dfsw_pkg::CTRL_SQUARE;
        end else if (set_wave == dfsw_pkg::WAVE_TRIANGLE) begin
            ctrl = ctrl | dfsw_pkg::CTRL_TRI;
        end
        dds_words_q.push_back(dds_word_t'{ctrl | dfsw_pkg::CTRL_RESET, 1'b0});
        dds_words_q.push_back(dds_word_t'{{dfsw_pkg::REG_SEL, tune[13:0]}, 1'b0});
        dds_words_q.push_back(dds_word_t'{{dfsw_pkg::REG_SEL, tune[27:14]}, 1'b0});
        dds_words_q.push_back(dds_word_t'{dfsw_pkg::PHASE_WORD, 1'b0});
        dds_words_q.push_back(dds_word_t'{ctrl, 1'b1});
    endfunction

    function automatic void advance_frequency(input logic mode, input logic [CFG_W-1:0] freq);
        logic [CFG_W:0] from;
        if (mode == dfsw_pkg::ITEM_LOAD) begin
            freq_hz = freq;
            queue_dds_words();
        end else if (set_enable) begin
            from = {1'b0, freq_hz};
            case (set_mode)
                dfsw_pkg::SWEEP_BOUNCE: begin
                    if (freq_hz >= set_upper) begin
                        going_up = 1'b0;
                    end else if (freq_hz <= set_lower) begin
                        going_up = 1'b1;
                    end
                end
                dfsw_pkg::SWEEP_RISE: begin
                    going_up = 1'b1;
                    if (freq_hz >= set_upper) from = {1'b0, set_lower};
                end
                dfsw_pkg::SWEEP_FALL: begin
                    going_up = 1'b0;
                    if (freq_hz <= set_lower) from = {1'b0, set_upper};
                end
                default: ;
            endcase
            if (going_up) begin
                from = from + {1'b0, set_step};
                freq_hz = from[CFG_W] ? FREQ_TOP : from[CFG_W-1:0];
            end else begin
                freq_hz = (from >= {1'b0, set_step}) ?
                          CFG_W'(from - {1'b0, set_step}) : '0;
            end
            queue_dds_words();
        end
    endfunction

    // output check and receiver stall pattern
    always @(posedge aclk) begin : word_check
        dds_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (dds_words_q.size() == 0) begin
                $error("spi_word: expected none, actual %h", m_spi_word);
                fail_count++;
            end else begin
                want = dds_words_q.pop_front();
                words_checked++;
                if (m_spi_word !== want.spi_word) begin
                    $error("spi_word: expected %h, actual %h", want.spi_word, m_spi_word);
                    fail_count++;
                end
                if (m_last_word !== want.last_word) begin
                    $error("last_word: expected %0b, actual %0b", want.last_word, m_last_word);
                    fail_count++;
                end
            end
        end
        if (stall_cycles == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_cycles <= $urandom_range(20, 80);
        end else begin
            stall_cycles <= stall_cycles - 1;
        end
        case (stall_style)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (stall_cycles % 4 == 0);
            default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_request(input logic mode, input logic [CFG_W-1:0] freq);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_mode <= mode;
        s_new_freq <= freq;
        do @(posedge aclk); while (!s_ready);
        advance_frequency(mode, freq);
        if (mode == dfsw_pkg::ITEM_LOAD) loads_sent++;
        else ticks_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (dds_words_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input dfsw_pkg::reg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dfsw_pkg::REG_WAVEFORM:     set_wave = data[1:0];
            dfsw_pkg::REG_SWEEP_ENABLE: set_enable = data[0];
            dfsw_pkg::REG_SWEEP_MODE:   set_mode = data[1:0];
            dfsw_pkg::REG_LOWER_FREQ:   set_lower = data;
            dfsw_pkg::REG_UPPER_FREQ:   set_upper = data;
            dfsw_pkg::REG_FREQ_STEP:    set_step = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input dfsw_pkg::cfg_t c);
        wait_idle();
        write_reg(dfsw_pkg::REG_WAVEFORM, CFG_W'(c.waveform));
        write_reg(dfsw_pkg::REG_SWEEP_ENABLE, CFG_W'(c.sweep_enable));
        write_reg(dfsw_pkg::REG_SWEEP_MODE, CFG_W'(c.sweep_mode));
        write_reg(dfsw_pkg::REG_LOWER_FREQ, c.lower_freq);
        write_reg(dfsw_pkg::REG_UPPER_FREQ, c.upper_freq);
        write_reg(dfsw_pkg::REG_FREQ_STEP, c.freq_step);
        cfg_valid <= 1'b0;
    endtask

    function automatic dfsw_pkg::cfg_t random_setting();
        dfsw_pkg::cfg_t c;
        c.waveform = dfsw_pkg::waveform_t'($urandom_range(0, 3));
        c.sweep_enable = ($urandom_range(0, 4) != 0);
        c.sweep_mode = dfsw_pkg::sweep_mode_t'(
            ($urandom_range(0, 6) == 6) ? 3 : $urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0: begin
                c.lower_freq = CFG_W'($urandom_range(0, 5000));
                c.upper_freq = c.lower_freq + CFG_W'($urandom_range(0, 5000));
            end
            1: begin
                c.lower_freq = CFG_W'($urandom);
                c.upper_freq = CFG_W'($urandom);
            end
            2: begin
                c.lower_freq = '0;
                c.upper_freq = FREQ_TOP;
            end
            default: begin
                c.lower_freq = FREQ_TOP - CFG_W'($urandom_range(0, 1000));
                c.upper_freq = FREQ_TOP;
            end
        endcase
        case ($urandom_range(0, 7))
            0: c.freq_step = '0;
            1: c.freq_step = FREQ_TOP;
            2: c.freq_step = CFG_W'($urandom);
            default: c.freq_step = CFG_W'($urandom_range(1, 600));
        endcase
        return c;
    endfunction

    task automatic test_disabled_ticks();
        send_request(dfsw_pkg::ITEM_TICK, '0);
        send_request(dfsw_pkg::ITEM_TICK, FREQ_TOP);
    endtask

    task automatic test_reset_frequency();
        apply_setting(dfsw_pkg::cfg_t'{dfsw_pkg::WAVE_SINE, 1'b1, dfsw_pkg::SWEEP_BOUNCE,
                                       24'd0, 24'd0, 24'd0});
        send_request(dfsw_pkg::ITEM_TICK, '0);
    endtask

    task automatic test_load_extremes();
        apply_setting(dfsw_pkg::cfg_t'{dfsw_pkg::WAVE_SINE, 1'b0, dfsw_pkg::SWEEP_BOUNCE,
                                       24'd0, 24'd0, 24'd0});
        send_request(dfsw_pkg::ITEM_LOAD, '0);
        send_request(dfsw_pkg::ITEM_LOAD, FREQ_TOP);
        send_request(dfsw_pkg::ITEM_LOAD, 24'h5A_A5C3);
    endtask

    task automatic test_waveform_codes();
        for (int w = 0; w < 4; w++) begin
            apply_setting(dfsw_pkg::cfg_t'{dfsw_pkg::waveform_t'(w), 1'b0,
                                           dfsw_pkg::SWEEP_RISE, 24'd0, FREQ_TOP, 24'd1});
            send_request(dfsw_pkg::ITEM_LOAD, CFG_W'(1_234_567 * (w + 1)));
        end
    endtask

    task automatic test_saturation();
        apply_setting(dfsw_pkg::cfg_t'{dfsw_pkg::WAVE_SQUARE, 1'b1, dfsw_pkg::SWEEP_RISE,
                                       24'd0, FREQ_TOP, FREQ_TOP});
        send_request(dfsw_pkg::ITEM_LOAD, FREQ_TOP - 24'd15);
        send_request(dfsw_pkg::ITEM_TICK, '0);
        send_request(dfsw_pkg::ITEM_TICK, '0);
        apply_setting(dfsw_pkg::cfg_t'{dfsw_pkg::WAVE_TRIANGLE, 1'b1, dfsw_pkg::SWEEP_FALL,
                                       24'd0, FREQ_TOP, FREQ_TOP});
        send_request(dfsw_pkg::ITEM_LOAD, 24'd10);
        send_request(dfsw_pkg::ITEM_TICK, '0);
        send_request(dfsw_pkg::ITEM_TICK, '0);
    endtask

    task automatic test_bounce_sweep();
        apply_setting(dfsw_pkg::cfg_t'{dfsw_pkg::WAVE_SINE, 1'b1, dfsw_pkg::SWEEP_BOUNCE,
                                       24'd100, 24'd130, 24'd7});
        send_request(dfsw_pkg::ITEM_LOAD, 24'd100);
        repeat (6) send_request(dfsw_pkg::ITEM_TICK, '0);
    endtask

    task automatic test_mode_three_hold();
        apply_setting(dfsw_pkg::cfg_t'{dfsw_pkg::WAVE_SINE, 1'b1,
                                       dfsw_pkg::sweep_mode_t'(2'd3),
                                       24'd0, 24'd1000, 24'd50});
        send_request(dfsw_pkg::ITEM_LOAD, 24'd500);
        repeat (2) send_request(dfsw_pkg::ITEM_TICK, '0);
    endtask

    task automatic test_random_sweeps();
        int             counted;
        int             phase;
        dfsw_pkg::cfg_t c;
        logic           load;
        counted = 0;
        phase = 0;
        while (counted < TARGET_ITEMS) begin
            if (phase == 0) begin
                c = dfsw_pkg::cfg_t'{dfsw_pkg::WAVE_TRIANGLE, 1'b1, dfsw_pkg::SWEEP_FALL,
                                     FREQ_TOP, FREQ_TOP, FREQ_TOP};
            end else if (phase == 1) begin
                c = dfsw_pkg::cfg_t'{dfsw_pkg::WAVE_SINE, 1'b1, dfsw_pkg::SWEEP_BOUNCE,
                                     24'd0, 24'd0, 24'd0};
            end else begin
                c = random_setting();
            end
            apply_setting(c);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(15, 30)) begin
                load = ($urandom_range(0, 7) == 0);
                counted++;
                if (load && $urandom_range(0, 1)) begin
                    send_request(dfsw_pkg::ITEM_LOAD, CFG_W'($urandom));
                end else if (load) begin
                    send_request(dfsw_pkg::ITEM_LOAD,
                                 CFG_W'($urandom_range(set_lower, set_upper)));
                end else begin
                    send_request(dfsw_pkg::ITEM_TICK, CFG_W'($urandom));
                end
            end
            phase++;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_disabled_ticks();
        test_reset_frequency();
        test_load_extremes();
        test_waveform_codes();
        test_saturation();
        test_bounce_sweep();
        test_mode_three_hold();
        test_random_sweeps();
        wait_idle();
        $display("covered %0d loads and %0d sweep ticks over all waveform and sweep modes",
                 loads_sent, ticks_sent);
        $display("%0d dds words compared, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
